// ===== rtl/actb_pkg.sv =====
// shared types and constants of the trie builder
package actb_pkg;

   localparam int NODES_DEF    = 256;
   localparam int ALPHABET_DEF = 3;
   localparam int TAG_BITS_DEF = 6;

   // operation codes
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_BUILD  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_RD_WAIT,
      ST_BLD_POP,
      ST_BLD_SYM,
      ST_BLD_GOTO,
      ST_BLD_CHAIN,
      ST_BLD_FAILRD,
      ST_BLD_PFAIL,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/actb_ram.sv =====
// generic single-port-write synchronous ram with registered read
module actb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/aho_corasick_trie_builder_unit.sv =====
// top level of the aho-corasick trie builder
//
// Each request gives exactly one response. The trie lives in goto, fail and tag memories with
// one write and one read port each, beside a breadth-first work queue memory. After reset and
// after a clear request the goto, fail and tag memories are swept back to empty, one goto slot
// per cycle; no request is taken during the sweep, while the clear response is offered at once.
// A read, and an insert with an out-of-range symbol, pass through a read wait state and then
// the response state; any other insert first goes through goto read, follow or allocate, then
// fail and tag read. Build pops each queued node and reads its symbol slots one by one; for a
// child of a non-root node it also walks the failure chain hop by hop; its response follows
// the final empty-queue check. One request is worked on at a time; the response register holds
// a result until it is taken and no request is taken while it is full.
module aho_corasick_trie_builder_unit #(
   parameter int NODES    = actb_pkg::NODES_DEF,
   parameter int ALPHABET = actb_pkg::ALPHABET_DEF,
   parameter int TAG_BITS = actb_pkg::TAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   // symbol[1:0], pattern_tag[7:2], node_index[15:8]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // node_id[7:0], fail_link[15:8], tag_valid[16], tag_value[22:17],
   // overflow[23], node_count[31:24]
   output logic [31:0] rsp_tdata
);

   localparam int NB  = $clog2(NODES);
   localparam int SB  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int GD  = NODES * ALPHABET;
   localparam int GB  = $clog2(GD);
   localparam int CB  = NB + 1;
   localparam int TW  = TAG_BITS + 1;

   // request fields
   actb_pkg::op_type op;
   logic [1:0] req_sym;
   logic       req_last;
   logic [5:0] req_tag;
   logic [7:0] req_idx;
   assign op       = actb_pkg::op_type'(req_tuser);
   assign req_sym  = req_tdata[1:0];
   assign req_last = req_tlast;
   assign req_tag  = req_tdata[7:2];
   assign req_idx  = req_tdata[15:8];

   actb_pkg::state_type state_ff, state_in;

   // working registers
   logic [NB-1:0] cursor_ff, cursor_in;
   logic [CB-1:0] alloc_ff, alloc_in;
   logic [NB-1:0] clr_ff, clr_in;
   logic [SB-1:0] sym_ff, sym_in;
   logic          last_ff, last_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [NB-1:0] node_ff, node_in;       // node being reported, or bfs current
   logic [CB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [NB-1:0] child_ff, child_in;
   logic [NB-1:0] p_ff, p_in;
   logic [NB:0]   guard_ff, guard_in;
   logic          oob_ff, oob_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    raw_id_ff, raw_id_in;

   // response register
   logic        rv_ff, rv_in;
   logic [31:0] rd_ff, rd_in;

   // memories
   logic          g_we;  logic [GB-1:0] g_wa, g_ra; logic [NB:0] g_wd, g_rd;
   logic          f_we;  logic [NB-1:0] f_wa, f_ra, f_wd, f_rd;
   logic          t_we;  logic [NB-1:0] t_wa, t_ra; logic [TW-1:0] t_wd, t_rd;
   logic          q_we;  logic [NB-1:0] q_wa, q_ra, q_wd, q_rd;

   actb_ram #(.WIDTH(NB + 1), .DEPTH(GD)) u_goto (
      .clock, .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd), .rd_addr(g_ra), .rd_data(g_rd));
   actb_ram #(.WIDTH(NB), .DEPTH(NODES)) u_fail (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));
   actb_ram #(.WIDTH(TW), .DEPTH(NODES)) u_tag (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   actb_ram #(.WIDTH(NB), .DEPTH(NODES)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd), .rd_addr(q_ra), .rd_data(q_rd));

   function automatic logic [GB-1:0] gaddr(input logic [NB-1:0] n, input logic [SB-1:0] s);
      logic [GB+SB:0] a;
      a = GB'(n) * (GB+SB+1)'(ALPHABET) + (GB+SB+1)'(s);
      return a[GB-1:0];
   endfunction

   function automatic logic [31:0] pack(input logic [7:0] id, input logic [7:0] fl,
         input logic tv, input logic [5:0] tg, input logic ov, input logic [7:0] cnt);
      return {cnt, ov, tg, tv, fl, id};
   endfunction

   assign req_tready = (state_ff == actb_pkg::ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   logic [7:0] cnt8;
   assign cnt8 = 8'(alloc_ff);

   // state register and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= actb_pkg::ST_CLEAR;
         clr_ff    <= '0;
         sym_ff    <= '0;
         cursor_ff <= '0;
         alloc_ff  <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         sym_ff    <= sym_in;
         cursor_ff <= cursor_in;
         alloc_ff  <= alloc_in;
         rv_ff     <= rv_in;
      end
      last_ff <= last_in;  tag_ff <= tag_in;
      node_ff <= node_in; head_ff <= head_in;  tail_ff <= tail_in;
      child_ff <= child_in; p_ff <= p_in;      guard_ff <= guard_in;
      oob_ff <= oob_in;   ovf_ff <= ovf_in;    raw_id_ff <= raw_id_in; rd_ff <= rd_in;
   end

   // sequencer
   always_comb begin
      logic [CB-1:0] na;
      logic [NB-1:0] nxt;
      logic [CB:0]   t1;
      state_in = state_ff;
      cursor_in = cursor_ff; alloc_in = alloc_ff; clr_in = clr_ff;
      sym_in = sym_ff; last_in = last_ff; tag_in = tag_ff; node_in = node_ff;
      head_in = head_ff; tail_in = tail_ff; child_in = child_ff; p_in = p_ff;
      guard_in = guard_ff; oob_in = oob_ff; ovf_in = ovf_ff; raw_id_in = raw_id_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
      f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
      t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
      q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
      na = alloc_ff + CB'(1);
      nxt = '0;
      t1 = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      unique case (state_ff)
         // sweep every node: goto slots, fail link and tag back to reset
         actb_pkg::ST_CLEAR: begin
            f_we = 1'b1; f_wa = clr_ff; f_wd = '0;
            t_we = 1'b1; t_wa = clr_ff; t_wd = '0;
            g_we = 1'b1; g_wa = gaddr(clr_ff, sym_ff); g_wd = {1'b1, {NB{1'b0}}};
            if (sym_ff == SB'(ALPHABET - 1)) begin
               sym_in = '0;
               clr_in = clr_ff + NB'(1);
               if (clr_ff == NB'(NODES - 1)) begin
                  state_in = actb_pkg::ST_IDLE;
               end
            end else begin
               sym_in = sym_ff + SB'(1);
            end
         end
         actb_pkg::ST_IDLE: begin
            sym_in = '0;
            if (req_tvalid && req_tready) begin
               ovf_in = 1'b0;
               unique case (op)
                  actb_pkg::OP_CLEAR: begin
                     cursor_in = '0; alloc_in = '0; clr_in = '0; sym_in = '0;
                     rv_in = 1'b1; rd_in = '0;
                     state_in = actb_pkg::ST_CLEAR;
                  end
                  actb_pkg::OP_INSERT: begin
                     sym_in = req_sym[SB-1:0]; last_in = req_last;
                     tag_in = req_tag[TAG_BITS-1:0];
                     if (32'(req_sym) >= ALPHABET) begin
                        node_in = cursor_ff; raw_id_in = 8'(cursor_ff); oob_in = 1'b0;
                        f_ra = cursor_ff; t_ra = cursor_ff;
                        state_in = actb_pkg::ST_RD_WAIT;
                     end else begin
                        g_ra = gaddr(cursor_ff, req_sym[SB-1:0]);
                        state_in = actb_pkg::ST_INS_RD;
                     end
                  end
                  actb_pkg::OP_BUILD: begin
                     q_we = 1'b1; q_wa = '0; q_wd = '0;
                     head_in = '0; tail_in = CB'(1);
                     state_in = actb_pkg::ST_BLD_POP;
                  end
                  default: begin
                     raw_id_in = req_idx;
                     oob_in = 32'(req_idx) >= NODES;
                     node_in = NB'(req_idx);
                     f_ra = NB'(req_idx); t_ra = NB'(req_idx);
                     state_in = actb_pkg::ST_RD_WAIT;
                  end
               endcase
            end
         end
         // goto entry is out; follow or allocate
         actb_pkg::ST_INS_RD: begin
            if (g_rd[NB]) begin
               if (32'(na) >= NODES) begin
                  raw_id_in = 8'(cursor_ff); node_in = cursor_ff; oob_in = 1'b0;
                  f_ra = cursor_ff; t_ra = cursor_ff;
                  if (last_ff) cursor_in = '0;
                  ovf_in = 1'b1;
                  state_in = actb_pkg::ST_INS_WR;
               end else begin
                  alloc_in = na;
                  nxt = NB'(na);
                  g_we = 1'b1; g_wa = gaddr(cursor_ff, sym_ff); g_wd = {1'b0, nxt};
                  node_in = nxt; raw_id_in = 8'(nxt); oob_in = 1'b0;
                  if (last_ff) begin t_we = 1'b1; t_wa = nxt; t_wd = {1'b1, tag_ff}; end
                  f_ra = nxt; t_ra = nxt;
                  cursor_in = last_ff ? '0 : nxt;
                  state_in = actb_pkg::ST_INS_WR;
               end
            end else begin
               nxt = g_rd[NB-1:0];
               node_in = nxt; raw_id_in = 8'(nxt); oob_in = 1'b0;
               if (last_ff) begin t_we = 1'b1; t_wa = nxt; t_wd = {1'b1, tag_ff}; end
               f_ra = nxt; t_ra = nxt;
               cursor_in = last_ff ? '0 : nxt;
               state_in = actb_pkg::ST_INS_WR;
            end
         end
         // tag write just happened; read once more to see it
         actb_pkg::ST_INS_WR: begin
            f_ra = node_ff; t_ra = node_ff;
            state_in = actb_pkg::ST_RD_WAIT;
            oob_in = oob_ff;
            tag_in = tag_ff;
         end
         actb_pkg::ST_RD_WAIT: begin
            f_ra = node_ff; t_ra = node_ff;
            state_in = actb_pkg::ST_RESP;
         end
         actb_pkg::ST_RESP: begin
            rv_in = 1'b1;
            if (oob_ff) begin
               rd_in = pack(raw_id_ff, 8'd0, 1'b0, 6'd0, 1'b0, cnt8);
            end else begin
               rd_in = pack(raw_id_ff, 8'(f_rd), t_rd[TAG_BITS], 6'(t_rd[TAG_BITS-1:0]),
                            ovf_ff, cnt8);
            end
            state_in = actb_pkg::ST_IDLE;
         end
         // breadth-first pass: pop next node
         actb_pkg::ST_BLD_POP: begin
            if (head_ff >= tail_ff) begin
               rv_in = 1'b1;
               rd_in = pack(8'd0, 8'd0, 1'b0, 6'd0, 1'b0, cnt8);
               state_in = actb_pkg::ST_IDLE;
            end else begin
               q_ra = head_ff[NB-1:0];
               head_in = head_ff + CB'(1);
               sym_in = '0;
               state_in = actb_pkg::ST_BLD_SYM;
            end
         end
         // popped node is out; read its first goto slot and its failure link
         actb_pkg::ST_BLD_SYM: begin
            node_in = q_rd;
            g_ra = gaddr(q_rd, sym_ff);
            f_ra = q_rd;
            state_in = actb_pkg::ST_BLD_GOTO;
         end
         actb_pkg::ST_BLD_GOTO: begin
            guard_in = '0;
            if (g_rd[NB]) begin
               state_in = actb_pkg::ST_BLD_FAILRD;
               p_in = '1;
            end else begin
               child_in = g_rd[NB-1:0];
               if (node_ff == '0) begin
                  f_we = 1'b1; f_wa = g_rd[NB-1:0]; f_wd = '0;
                  state_in = actb_pkg::ST_BLD_FAILRD;
                  p_in = '0;
                  if (32'(tail_ff) < NODES) begin
                     q_we = 1'b1; q_wa = tail_ff[NB-1:0]; q_wd = g_rd[NB-1:0];
                     tail_in = tail_ff + CB'(1);
                  end
               end else begin
                  p_in = f_rd;
                  g_ra = gaddr(f_rd, sym_ff);
                  f_ra = f_rd;
                  state_in = actb_pkg::ST_BLD_CHAIN;
               end
            end
         end
         // failure-chain hop: goto of p and fail of p are out
         actb_pkg::ST_BLD_CHAIN: begin
            if (!g_rd[NB] || p_ff == '0 || 32'(guard_ff) >= NODES - 1) begin
               f_we = 1'b1; f_wa = child_ff;
               f_wd = (!g_rd[NB]) ? g_rd[NB-1:0] : '0;
               if (32'(tail_ff) < NODES) begin
                  q_we = 1'b1; q_wa = tail_ff[NB-1:0]; q_wd = child_ff;
                  tail_in = tail_ff + CB'(1);
               end
               p_in = '0;
               state_in = actb_pkg::ST_BLD_FAILRD;
            end else begin
               guard_in = guard_ff + (NB+1)'(1);
               p_in = f_rd;
               g_ra = gaddr(f_rd, sym_ff);
               f_ra = f_rd;
               state_in = actb_pkg::ST_BLD_PFAIL;
            end
         end
         actb_pkg::ST_BLD_PFAIL: begin
            g_ra = gaddr(p_ff, sym_ff);
            f_ra = p_ff;
            state_in = actb_pkg::ST_BLD_CHAIN;
         end
         // next symbol slot of the current node, or back to pop after the last
         actb_pkg::ST_BLD_FAILRD: begin
            t1 = (CB+1)'(sym_ff) + (CB+1)'(1);
            if (32'(t1) >= ALPHABET) begin
               state_in = actb_pkg::ST_BLD_POP;
            end else begin
               sym_in = sym_ff + SB'(1);
               guard_in = '1;
               g_ra = gaddr(node_ff, sym_ff + SB'(1));
               f_ra = node_ff;
               state_in = actb_pkg::ST_BLD_GOTO;
            end
         end
         default: state_in = actb_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/actb_checker.sv =====
// port-level checks of the trie builder, bound to the top level
module actb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a pending response holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // no request taken while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with response pending");

   // clear response is all zero
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == actb_pkg::OP_CLEAR
         |=> rsp_tvalid && rsp_tdata == 32'd0)
      else $error("clear response not zero");

   // root always reports a zero failure link
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] == 8'd0 |-> rsp_tdata[15:8] == 8'd0)
      else $error("root reported with nonzero failure link");

endmodule

bind aho_corasick_trie_builder_unit actb_checker u_actb_checker (.*);

// ===== bench/tb.sv =====
// testbench of the aho-corasick trie builder: scoreboard against a behavioral trie model
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_NODES = 256;
   localparam int N_SYM   = 3;
   localparam int WATCHDOG_LIMIT = 200000;

   // packed in port order, highest field first
   typedef struct packed {
      logic [7:0] node_count;
      logic       overflow;
      logic [5:0] tag_value;
      logic       tag_valid;
      logic [7:0] fail_link;
      logic [7:0] node_id;
   } trie_resp_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic [15:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;

   aho_corasick_trie_builder_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tlast(req_tlast), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // model state of the trie
   bit         go_ok [N_NODES*N_SYM];
   int         go_to [N_NODES*N_SYM];
   int         fail_of [N_NODES];
   bit         tag_ok [N_NODES];
   int         tag_of [N_NODES];
   int         node_total;
   int         cursor;

   // pending requests as op[1:0], symbol[3:2], pattern_end[4], tag[10:5], index[18:11]
   logic [23:0]   pending_reqs[$];
   trie_resp_type expected_resps[$];
   int          errors = 0;
   bit          hold_rsp = 0;   // long stall request for the receiver
   int          sent_count = 0;
   bit          req_taken = 0;
   bit          rsp_taken = 0;

   task automatic trie_clear();
      for (int i = 0; i < N_NODES*N_SYM; i++) begin
         go_ok[i] = 0;
         go_to[i] = 0;
      end
      for (int i = 0; i < N_NODES; i++) begin
         fail_of[i] = 0;
         tag_ok[i] = 0;
         tag_of[i] = 0;
      end
      node_total = 0;
      cursor = 0;
   endtask

   function automatic trie_resp_type node_report(int node, bit ovf);
      trie_resp_type r;
      r = '0;
      r.node_id = node[7:0];
      if (node < N_NODES) begin
         r.fail_link = fail_of[node][7:0];
         r.tag_valid = tag_ok[node];
         r.tag_value = tag_of[node][5:0];
      end
      r.overflow = ovf;
      r.node_count = node_total[7:0];
      return r;
   endfunction

   // breadth-first failure link pass
   task automatic trie_build_links();
      int q[$];
      int cur, child, link, p;
      q.push_back(0);
      while (q.size() > 0) begin
         cur = q.pop_front();
         for (int s = 0; s < N_SYM; s++) begin
            if (!go_ok[cur*N_SYM+s]) continue;
            child = go_to[cur*N_SYM+s];
            link = 0;
            if (cur != 0) begin
               p = fail_of[cur];
               for (int g = 0; g < N_NODES; g++) begin
                  if (go_ok[p*N_SYM+s]) begin
                     link = go_to[p*N_SYM+s];
                     break;
                  end
                  if (p == 0) break;
                  p = fail_of[p];
               end
            end
            fail_of[child] = link;
            q.push_back(child);
         end
      end
   endtask

   // predicted response of one request
   task automatic trie_apply(logic [23:0] d, output trie_resp_type r);
      actb_pkg::op_type op;
      logic [1:0] sym;
      logic       last;
      logic [5:0] tag;
      int         e, nxt;
      op = actb_pkg::op_type'(d[1:0]);
      sym = d[3:2];
      last = d[4];
      tag = d[10:5];
      case (op)
         actb_pkg::OP_CLEAR: begin
            trie_clear();
            r = node_report(0, 0);
            r.fail_link = 0; r.tag_valid = 0; r.tag_value = 0;
         end
         actb_pkg::OP_INSERT: begin
            if (sym >= N_SYM) begin
               r = node_report(cursor, 0);
            end else begin
               e = cursor*N_SYM + sym;
               if (!go_ok[e] && node_total + 1 >= N_NODES) begin
                  r = node_report(cursor, 1);
                  if (last) cursor = 0;
               end else begin
                  if (!go_ok[e]) begin
                     node_total++;
                     go_ok[e] = 1;
                     go_to[e] = node_total;
                  end
                  nxt = go_to[e];
                  if (last) begin
                     tag_ok[nxt] = 1;
                     tag_of[nxt] = tag;
                  end
                  r = node_report(nxt, 0);
                  cursor = last ? 0 : nxt;
               end
            end
         end
         actb_pkg::OP_BUILD: begin
            trie_build_links();
            r = node_report(0, 0);
            r.fail_link = 0; r.tag_valid = 0; r.tag_value = 0;
         end
         default: r = node_report(d[18:11], 0);
      endcase
   endtask

   function automatic logic [23:0] pack_req(actb_pkg::op_type op, int sym, bit last, int tag,
         int idx);
      logic [23:0] d;
      d = '0;
      d[1:0] = op;
      d[3:2] = sym[1:0];
      d[4] = last;
      d[10:5] = tag[5:0];
      d[18:11] = idx[7:0];
      return d;
   endfunction

   // random pattern of length 1..len_max with random symbols
   task automatic queue_pattern(int len_max, bit allow_bad);
      int len;
      len = $urandom_range(1, len_max);
      for (int i = 0; i < len; i++)
         pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT,
            allow_bad ? $urandom_range(0, 3) : $urandom_range(0, 2),
            i == len-1, $urandom_range(0, 63), $urandom));
   endtask

   // clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // handshakes seen at the last rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
   end

   // driver
   int drv_gap = 0;
   logic [23:0] drv_word;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tuser <= '0;
         req_tlast <= 0;
         req_tdata <= '0;
         drv_gap <= $urandom_range(0, 18);
      end else if (req_tvalid && !req_taken) begin
         // hold the offered request
      end else if (drv_gap > 0) begin
         req_tvalid <= 0;
         drv_gap <= drv_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         drv_word = pending_reqs.pop_front();
         req_tvalid <= 1;
         req_tuser <= drv_word[1:0];
         req_tlast <= drv_word[4];
         req_tdata <= {drv_word[18:11], drv_word[10:5], drv_word[3:2]};
         drv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      end else begin
         req_tvalid <= 0;
      end
   end

   // receiver ready with random stalls
   int rcv_gap = 0;
   int rcv_draw;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rcv_gap <= 0;
      end else if (hold_rsp) begin
         rsp_tready <= 0;
      end else if (rsp_taken) begin
         rcv_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         rsp_tready <= (rcv_draw == 0);
         rcv_gap <= rcv_draw;
      end else if (rcv_gap > 0) begin
         rsp_tready <= 0;
         rcv_gap <= rcv_gap - 1;
      end else begin
         rsp_tready <= 1;
      end
   end

   // prediction on accepted requests and comparison on accepted responses
   trie_resp_type got, want;
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         trie_apply({5'd0, req_tdata[15:8], req_tdata[7:2], req_tlast, req_tdata[1:0],
                     req_tuser}, want);
         expected_resps.push_back(want);
         sent_count <= sent_count + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = trie_resp_type'(rsp_tdata);
         if (expected_resps.size() == 0) begin
            $error("response with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_resps.pop_front();
            if (got.node_id != want.node_id) begin
               $error("node_id exp %0d got %0d", want.node_id, got.node_id); errors++;
            end
            if (got.fail_link != want.fail_link) begin
               $error("fail_link exp %0d got %0d", want.fail_link, got.fail_link); errors++;
            end
            if (got.tag_valid != want.tag_valid) begin
               $error("tag_valid exp %0d got %0d", want.tag_valid, got.tag_valid); errors++;
            end
            if (got.tag_value != want.tag_value) begin
               $error("tag_value exp %0d got %0d", want.tag_value, got.tag_value); errors++;
            end
            if (got.overflow != want.overflow) begin
               $error("overflow exp %0d got %0d", want.overflow, got.overflow); errors++;
            end
            if (got.node_count != want.node_count) begin
               $error("node_count exp %0d got %0d", want.node_count, got.node_count); errors++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // long receiver stall while the sender keeps offering
   initial begin
      wait (sent_count > 60);
      @(negedge clock);
      hold_rsp = 1;
      repeat (300) @(negedge clock);
      hold_rsp = 0;
   end

   // stimulus
   int mark;
   initial begin
      trie_clear();
      reset = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: shared prefixes, tag overwrite, bad symbol, build, reads, clear
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 1, 1, 63, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 1, 0, 0, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 2, 1, 5, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 3, 0, 9, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 1, 1, 42, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 2, 1, 1, 255));
      pending_reqs.push_back(pack_req(actb_pkg::OP_INSERT, 3, 1, 0, 0));
      pending_reqs.push_back(pack_req(actb_pkg::OP_BUILD, 3, 1, 63, 255));
      for (int i = 0; i < 6; i++)
         pending_reqs.push_back(pack_req(actb_pkg::OP_READ, 0, 0, 0, i));
      pending_reqs.push_back(pack_req(actb_pkg::OP_READ, 3, 1, 63, 255));
      pending_reqs.push_back(pack_req(actb_pkg::OP_CLEAR, 3, 1, 63, 255));
      pending_reqs.push_back(pack_req(actb_pkg::OP_READ, 0, 0, 0, 2));

      // random phase: patterns, builds, reads, noise, occasional clears
      while (pending_reqs.size() < 380) begin
         case ($urandom_range(0, 19))
            0: pending_reqs.push_back(pack_req(actb_pkg::OP_CLEAR, $urandom, $urandom,
                  $urandom, $urandom));
            1, 2: pending_reqs.push_back(pack_req(actb_pkg::OP_BUILD, $urandom, $urandom,
                  $urandom, $urandom));
            3, 4, 5: pending_reqs.push_back(pack_req(actb_pkg::OP_READ, $urandom, $urandom,
                  $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40)));
            6: queue_pattern(6, 1);
            default: queue_pattern(6, 0);
         endcase
      end

      // sender pause until everything has come back
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_resps.size() == 0);
      repeat (5) @(negedge clock);

      // fill the store to overflow with long patterns, then build and read
      pending_reqs.push_back(pack_req(actb_pkg::OP_CLEAR, 0, 0, 0, 0));
      mark = 0;
      while (mark < 380) begin
         queue_pattern(12, 0);
         mark = pending_reqs.size();
      end
      pending_reqs.push_back(pack_req(actb_pkg::OP_BUILD, 0, 0, 0, 0));
      for (int i = 0; i < 40; i++)
         pending_reqs.push_back(pack_req(actb_pkg::OP_READ, 0, 0, 0, $urandom_range(0, 255)));
      pending_reqs.push_back(pack_req(actb_pkg::OP_READ, 0, 0, 0, 255));

      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_resps.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
